// ===== hdl/ecar_pkg.sv =====
// Package for the elementary cellular automaton ring engine.
// Holds the channel word types, operation and register codes and reset values.
// Used by every module of the block but ecar_fifo; depends on nothing.
package ecar_pkg;

	// Default ring size and the fixed width of one output slice.
	localparam int CELL_COUNT_DEF = 256;
	localparam int SLICE_W        = 64;

	// Operation codes carried by an input word.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;
	localparam logic [1:0] OP_EMIT  = 2'd3;

	// Configuration register indexes and their reset values.
	localparam logic CFG_RULE   = 1'b0;
	localparam logic CFG_THRESH = 1'b1;
	localparam logic [7:0] RULE_RESET   = 8'd110;
	localparam logic [7:0] THRESH_RESET = 8'd127;

	// Input word.
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] seed_byte;
	} in_item_t;

	// Result word: one 64-cell slice of the row.
	typedef struct packed {
		logic [1:0]         word_index;
		logic [SLICE_W-1:0] row_bits;
		logic               last_word;
	} out_item_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		logic [1:0] op;
		logic       alive;
	} cmd_t;

endpackage

// ===== hdl/ecar_fifo.sv =====
// Small first-in first-out queue of registers between front and back end.
// Generic in width and depth; depends on nothing.
module ecar_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/ecar_front.sv =====
// Front end: configuration registers and classification of input words.
// Depends on ecar_pkg; feeds the command queue.
module ecar_front
	import ecar_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd,
	output logic [7:0] rule_number
);

	logic [7:0] rule_q;
	logic [7:0] thresh_q;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= RULE_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RULE:   rule_q   <= cfg_data;
				CFG_THRESH: thresh_q <= cfg_data;
			endcase
		end
	end

	// The seed decision is made here so the back end only stores one bit.
	assign cmd_valid   = item_valid;
	assign item_ready  = cmd_ready;
	assign cmd.op      = item.operation;
	assign cmd.alive   = (item.seed_byte > thresh_q);
	assign rule_number = rule_q;

endmodule

// ===== hdl/ecar_back.sv =====
// Back end: the cell row, the generation update and the slice output register.
// Depends on ecar_pkg; takes commands from the queue.
module ecar_back
	import ecar_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	input  logic [7:0] rule_number,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result
);

	localparam int WORD_COUNT = (CELL_COUNT + SLICE_W - 1) / SLICE_W;
	localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int PAD_WORDS  = 2 ** WORD_W;
	localparam int IDX_W      = $clog2(CELL_COUNT);
	localparam int POS_W      = $clog2(CELL_COUNT + 1);

	logic [CELL_COUNT-1:0]          row_q;
	logic [CELL_COUNT-1:0]          next_row;
	logic [POS_W-1:0]               pos_q;
	logic                           emitting_q;
	logic [WORD_W-1:0]              word_q;
	logic                           res_valid_q;
	out_item_t                      res_q;
	logic [PAD_WORDS*SLICE_W-1:0]   padded;
	logic [SLICE_W-1:0]             slice;
	logic                           cmd_take;
	logic                           load_slot;
	logic                           emit_load;
	logic                           is_last;

	// Each cell looks up the rule by its left, own and right state on the ring.
	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		assign next_row[i] = rule_number[{row_q[(i + CELL_COUNT - 1) % CELL_COUNT],
			row_q[i], row_q[(i + 1) % CELL_COUNT]}];
	end

	// Row padded with dead cells up to whole slices, then the current slice.
	assign padded  = {{(PAD_WORDS*SLICE_W - CELL_COUNT){1'b0}}, row_q};
	assign slice   = padded[word_q*SLICE_W +: SLICE_W];
	assign is_last = (word_q == WORD_W'(WORD_COUNT - 1));

	assign cmd_ready = !emitting_q;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign load_slot = (pos_q < POS_W'(CELL_COUNT));
	assign emit_load = emitting_q && (!res_valid_q || result_ready);

	// Row, load position and slice sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			pos_q       <= '0;
			emitting_q  <= 1'b0;
			word_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				unique case (cmd.op)
					OP_CLEAR: begin
						row_q <= '0;
						pos_q <= '0;
					end
					OP_LOAD: begin
						if (load_slot) begin
							row_q[pos_q[IDX_W-1:0]] <= cmd.alive;
							pos_q <= pos_q + POS_W'(1);
						end
					end
					OP_STEP: begin
						row_q      <= next_row;
						emitting_q <= 1'b1;
						word_q     <= '0;
					end
					OP_EMIT: begin
						emitting_q <= 1'b1;
						word_q     <= '0;
					end
				endcase
			end
			if (emit_load) begin
				res_valid_q <= 1'b1;
				if (is_last) begin
					emitting_q <= 1'b0;
				end else begin
					word_q <= word_q + WORD_W'(1);
				end
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_q.word_index <= 2'(word_q);
			res_q.row_bits   <= slice;
			res_q.last_word  <= is_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hdl/elementary_ca_ring_engine_core.sv =====
// Top level of the elementary cellular automaton ring engine.
// Depends on ecar_pkg, ecar_front, ecar_fifo and ecar_back.

// A ring of CELL_COUNT cells is cleared, seeded one byte per input word and
// advanced by the configured eight-bit rule. Step and emit words produce
// ceil(CELL_COUNT/64) result words, one per cycle while the receiver does not
// stall, from a single 64-bit output register. The step, or the start of an
// emit, takes place when the word is accepted, and the slices follow it; the
// back end takes no new word until its last slice is loaded. A two-entry queue
// lets the front end take further words while the back end is still sending.
module elementary_ca_ring_engine_core
	import ecar_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic       front_valid;
	logic       front_ready;
	cmd_t       front_cmd;
	logic       back_valid;
	logic       back_ready;
	cmd_t       back_cmd;
	logic [7:0] rule_number;

	ecar_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (front_valid),
		.cmd_ready   (front_ready),
		.cmd         (front_cmd),
		.rule_number (rule_number)
	);

	ecar_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	ecar_back #(
		.CELL_COUNT (CELL_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (back_valid),
		.cmd_ready    (back_ready),
		.cmd          (back_cmd),
		.rule_number  (rule_number),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== hdl/ecar_checker.sv =====
// Port-level checks on the cellular automaton engine, bound to the top level.
// Depends on ecar_pkg and elementary_ca_ring_engine_core.
module ecar_checker
	import ecar_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result,
	input logic      cfg_ready
);

	localparam int WORD_COUNT = (CELL_COUNT + SLICE_W - 1) / SLICE_W;

	// A stalled result word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// The final slice carries the last slice number.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_word |-> result.word_index == 2'(WORD_COUNT - 1))
		else $error("last word flag on the wrong slice");

	// Slices of one row follow each other without a gap and in order.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result.last_word |=>
			result_valid && result.word_index == 2'($past(result.word_index) + 2'd1))
		else $error("slice sequence broken");

	// Register writes are never held off.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration write stalled");

endmodule

bind elementary_ca_ring_engine_core ecar_checker #(
	.CELL_COUNT (CELL_COUNT)
) u_ecar_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_ready    (cfg_ready)
);

// ===== tb/tb_top.sv =====
// Testbench for elementary_ca_ring_engine_core: clears, seeds, steps and emits the cell ring.
// A behavioural copy of the ring checks every result word in order.
// Depends on ecar_pkg and the core RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ecar_pkg::*;

	localparam int CELLS        = CELL_COUNT_DEF;
	localparam int SLICES       = (CELLS + SLICE_W - 1) / SLICE_W;
	localparam int DRAIN_CYCLES = 16;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_ready;
	in_item_t   item         = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_item_t  result;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic       cfg_index    = 1'b0;
	logic [7:0] cfg_data     = 8'd0;

	// Behavioural copy of the ring, its load pointer and its two registers.
	logic [SLICES*SLICE_W-1:0] ring_cells = '0;
	int unsigned               load_ptr   = 0;
	logic [7:0]                rule_reg   = RULE_RESET;
	logic [7:0]                thresh_reg = THRESH_RESET;
	out_item_t                 pending_slices[$];

	int mismatches = 0;
	int words_sent = 0;
	int stall_left = 0;
	bit tx_quiet   = 1'b0;
	bit rx_quiet   = 1'b0;

	elementary_ca_ring_engine_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Applies one accepted input word to the ring copy and queues the slices it yields.
	function automatic void apply_word(in_item_t w);
		logic [SLICES*SLICE_W-1:0] nxt;
		out_item_t                 s;
		int                        l;
		int                        r;
		case (w.operation)
			OP_CLEAR: begin
				ring_cells = '0;
				load_ptr   = 0;
			end
			OP_LOAD: begin
				// Once the ring is full, further seed bytes change nothing.
				if (load_ptr < CELLS) begin
					ring_cells[load_ptr] = (w.seed_byte > thresh_reg);
					load_ptr++;
				end
			end
			default: begin
				// A step updates every cell from the old generation, wrapping at both ends.
				if (w.operation == OP_STEP) begin
					nxt = '0;
					for (int i = 0; i < CELLS; i++) begin
						l = (i == 0) ? CELLS - 1 : i - 1;
						r = (i == CELLS - 1) ? 0 : i + 1;
						nxt[i] = rule_reg[{ring_cells[l], ring_cells[i], ring_cells[r]}];
					end
					ring_cells = nxt;
				end
				for (int k = 0; k < SLICES; k++) begin
					s.word_index = 2'(k);
					s.row_bits   = ring_cells[k*SLICE_W +: SLICE_W];
					s.last_word  = (k == SLICES - 1);
					pending_slices.push_back(s);
				end
			end
		endcase
	endfunction

	// Sends one input word, after an optional gap, and records its effect once accepted.
	task automatic send_word(input logic [1:0] op, input logic [7:0] seed);
		in_item_t w;
		int       gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.operation = op;
		w.seed_byte = seed;
		item        <= w;
		item_valid  <= 1'b1;
		do @(posedge clk); while (!item_ready);
		apply_word(w);
		words_sent++;
	endtask

	// Holds the sender until every expected slice has arrived and the core has settled.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one register while the core is idle.
	task automatic write_reg(input logic idx, input logic [7:0] val);
		wait_idle();
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_RULE)
			rule_reg = val;
		else
			thresh_reg = val;
	endtask

	// Receiver back-pressure: random stalls, switched off while rx_quiet is set.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_ready <= 1'b0;
		end else begin
			stall_left = pick_gap(rx_quiet);
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Each result word is compared with the oldest expected slice.
	always @(posedge clk) begin
		out_item_t want;
		if (result_valid && result_ready) begin
			if (pending_slices.size() == 0) begin
				$display("%0t: expected no result word, got idx=%0d bits=%h last=%0b",
					$realtime, result.word_index, result.row_bits, result.last_word);
				mismatches++;
			end else begin
				want = pending_slices.pop_front();
				if (result.word_index !== want.word_index) begin
					$display("%0t: word_index expected %0d, got %0d", $realtime,
						want.word_index, result.word_index);
					mismatches++;
				end
				if (result.row_bits !== want.row_bits) begin
					$display("%0t: row_bits expected %h, got %h", $realtime,
						want.row_bits, result.row_bits);
					mismatches++;
				end
				if (result.last_word !== want.last_word) begin
					$display("%0t: last_word expected %0b, got %0b", $realtime,
						want.last_word, result.last_word);
					mismatches++;
				end
			end
		end
	end

	// An emit straight after reset shows an empty ring.
	task automatic test_reset_state();
		send_word(OP_EMIT, 8'hA5);
	endtask

	// Seed bytes either side of the default threshold, then two steps under rule 110.
	task automatic test_seed_threshold();
		send_word(OP_LOAD, 8'd127);
		send_word(OP_LOAD, 8'd128);
		send_word(OP_LOAD, 8'd0);
		send_word(OP_LOAD, 8'd255);
		send_word(OP_LOAD, 8'h55);
		send_word(OP_LOAD, 8'hAA);
		send_word(OP_LOAD, 8'd200);
		send_word(OP_EMIT, 8'h00);
		send_word(OP_STEP, 8'hFF);
		send_word(OP_STEP, 8'h3C);
	endtask

	// Rule 0 kills every cell, rule 255 revives every cell; then a clear empties the ring.
	task automatic test_rule_extremes();
		write_reg(CFG_RULE, 8'h00);
		send_word(OP_STEP, 8'h81);
		write_reg(CFG_RULE, 8'hFF);
		send_word(OP_STEP, 8'h7E);
		write_reg(CFG_RULE, RULE_RESET);
		send_word(OP_CLEAR, 8'hFF);
		send_word(OP_EMIT, 8'h5A);
	endtask

	// Lowest threshold and the highest one a byte can exceed, each with bytes on both sides.
	task automatic test_threshold_extremes();
		write_reg(CFG_THRESH, 8'd0);
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_LOAD, 8'd0);
		send_word(OP_LOAD, 8'd1);
		write_reg(CFG_THRESH, 8'd254);
		send_word(OP_LOAD, 8'd254);
		send_word(OP_LOAD, 8'd255);
		send_word(OP_EMIT, 8'hC3);
		write_reg(CFG_THRESH, THRESH_RESET);
	endtask

	// Fills the whole ring with a step part-way (the load pointer must survive it),
	// then checks that bytes beyond the last cell are ignored.
	task automatic test_fill_overflow();
		send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
		repeat (100) send_word(OP_LOAD, 8'($urandom_range(0, 255)));
		send_word(OP_STEP, 8'($urandom_range(0, 255)));
		send_word(OP_EMIT, 8'($urandom_range(0, 255)));
		repeat (CELLS - 100 + 2) send_word(OP_LOAD, 8'($urandom_range(0, 255)));
		send_word(OP_EMIT, 8'($urandom_range(0, 255)));
		send_word(OP_STEP, 8'($urandom_range(0, 255)));
		send_word(OP_LOAD, 8'($urandom_range(0, 255)));
		send_word(OP_EMIT, 8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed sequences (clear, seed, step or emit) under changing settings,
	// with some stretches of arbitrary words mixed in.
	task automatic test_random();
		int stop_at;
		int kind;
		int sel;
		stop_at = words_sent + 10;
		while (words_sent < stop_at) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			kind     = $urandom_range(0, 9);
			if ($urandom_range(0, 5) == 0)
				wait_idle();
			if (kind < 3) begin
				sel = $urandom_range(0, 5);
				write_reg(CFG_RULE, (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF
					: 8'($urandom_range(0, 255)));
				sel = $urandom_range(0, 5);
				write_reg(CFG_THRESH, (sel == 0) ? 8'd0 : (sel == 1) ? 8'd254
					: 8'($urandom_range(0, 254)));
			end
			if (kind < 8) begin
				send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
				repeat ($urandom_range(1, 12))
					send_word(OP_LOAD, 8'($urandom_range(0, 255)));
				repeat ($urandom_range(1, 3))
					send_word($urandom_range(0, 1) ? OP_STEP : OP_EMIT,
						8'($urandom_range(0, 255)));
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 6))
						send_word(OP_LOAD, 8'($urandom_range(0, 255)));
					send_word(OP_STEP, 8'($urandom_range(0, 255)));
				end
			end else begin
				repeat ($urandom_range(1, 8))
					send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_seed_threshold();
		test_rule_extremes();
		test_threshold_extremes();
		test_fill_overflow();
		test_random();
		wait_idle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
